>>> hdl/rme_pkg.sv
// ----------------------------------------------------------------------------
// Package for rotation-matrix-to-Euler conversion
// Shared constants, the arctangent table and the per-cell state type.
// ----------------------------------------------------------------------------
package rme_pkg;

   localparam int DATA_WIDTH_DEF    = 16;
   localparam int ANGLE_WIDTH_DEF   = 16;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam int FIELD_WIDTH  = 16;
   localparam int THR_WIDTH    = 15;
   localparam logic [THR_WIDTH-1:0] THR_RESET = 15'd16368;

   // Internal vector word: covers 2^44 scaling, the sum of two entries and growth.
   localparam int VEC_WIDTH = 50;
   localparam int PH_WIDTH  = 32;

   localparam logic [PH_WIDTH-1:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [PH_WIDTH-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [PH_WIDTH-1:0] NEG_QUARTER  = 32'hC000_0000;
   localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;

   typedef logic signed [VEC_WIDTH-1:0] vec_type;
   typedef logic [PH_WIDTH-1:0] phase_type;

   typedef struct packed {
      vec_type   x;
      vec_type   y;
      phase_type z;
   } cordic_type;

   function automatic phase_type atan_turn(input int i);
      phase_type t;
      case (i)
         0:  t = 32'h20000000;  1:  t = 32'h12E4051E;
         2:  t = 32'h09FB385B;  3:  t = 32'h051111D4;
         4:  t = 32'h028B0D43;  5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;  7:  t = 32'h00517C55;
         8:  t = 32'h0028BE53;  9:  t = 32'h00145F2F;
         10: t = 32'h000A2F98;  11: t = 32'h000517CC;
         12: t = 32'h00028BE6;  13: t = 32'h000145F3;
         14: t = 32'h0000A2FA;  15: t = 32'h0000517D;
         16: t = 32'h000028BE;  17: t = 32'h0000145F;
         18: t = 32'h00000A30;  19: t = 32'h00000518;
         20: t = 32'h0000028C;  21: t = 32'h00000146;
         22: t = 32'h000000A3;  23: t = 32'h00000051;
         24: t = 32'h00000029;  25: t = 32'h00000014;
         26: t = 32'h0000000A;  27: t = 32'h00000005;
         28: t = 32'h00000003;  29: t = 32'h00000001;
         30: t = 32'h00000001;  default: t = 32'h00000000;
      endcase
      return t;
   endfunction

   // Pre-rotation: zero vector gives zero; negative x is turned by a half turn.
   function automatic cordic_type cordic_pre(input vec_type x, input vec_type y);
      cordic_type c;
      c.x = x;
      c.y = y;
      c.z = '0;
      if (x < 0) begin
         c.x = -x;
         c.y = -y;
         c.z = HALF_TURN;
      end
      return c;
   endfunction

endpackage

>>> hdl/rme_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One vectoring micro-rotation for the three lanes, registered when the
// chain advances.
// ----------------------------------------------------------------------------
module rme_cell import rme_pkg::*; #(
   parameter int SHIFT = 0
) (
   input  logic       clock,
   input  logic       enable,
   input  cordic_type in_lane  [3],
   input  logic       in_zero  [3],
   output cordic_type out_lane [3],
   output logic       out_zero [3]
);

   localparam phase_type ATAN = atan_turn(SHIFT);

   cordic_type lane_in [3];
   cordic_type lane_ff [3];
   logic       zero_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (in_lane[k].y > 0) begin
            lane_in[k].x = in_lane[k].x + (in_lane[k].y >>> SHIFT);
            lane_in[k].y = in_lane[k].y - (in_lane[k].x >>> SHIFT);
            lane_in[k].z = in_lane[k].z + ATAN;
         end else begin
            lane_in[k].x = in_lane[k].x - (in_lane[k].y >>> SHIFT);
            lane_in[k].y = in_lane[k].y + (in_lane[k].x >>> SHIFT);
            lane_in[k].z = in_lane[k].z - ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff <= lane_in;
         zero_ff <= in_zero;
      end
   end

   assign out_lane = lane_ff;
   assign out_zero = zero_ff;

endmodule

>>> hdl/rme_chain.sv
// ----------------------------------------------------------------------------
// CORDIC cell chain
// A row of vectoring cells carrying three lanes with a side tag, valid bits
// moving alongside.
// ----------------------------------------------------------------------------
module rme_chain import rme_pkg::*; #(
   parameter int STAGES   = CORDIC_STAGES_DEF,
   parameter int TAG_BITS = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                in_valid,
   input  cordic_type          in_lane  [3],
   input  logic                in_zero  [3],
   input  logic [TAG_BITS-1:0] in_tag,
   output logic                out_valid,
   output cordic_type          out_lane [3],
   output logic                out_zero [3],
   output logic [TAG_BITS-1:0] out_tag
);

   localparam int N = (STAGES > 32) ? 32 : STAGES;

   cordic_type          lane [N+1][3];
   logic                zero [N+1][3];
   logic                vld_ff [N];
   logic [TAG_BITS-1:0] tag_ff [N];

   assign lane[0] = in_lane;
   assign zero[0] = in_zero;

   for (genvar s = 0; s < N; s++) begin : g_cell
      rme_cell #(.SHIFT(s)) u_cell (
         .clock   (clock),
         .enable  (enable),
         .in_lane (lane[s]),
         .in_zero (zero[s]),
         .out_lane(lane[s+1]),
         .out_zero(zero[s+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            tag_ff[s] <= (s == 0) ? in_tag : tag_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = vld_ff[N-1];
   assign out_lane  = lane[N];
   assign out_zero  = zero[N];
   assign out_tag   = tag_ff[N-1];

endmodule

>>> hdl/rotation_matrix_to_euler.sv
// ----------------------------------------------------------------------------
// Rotation matrix to ZYX Euler angles
// Converts a Q2.14 direction cosine matrix into roll, pitch and yaw.
// ----------------------------------------------------------------------------
// One request is accepted every cycle while the output is taken. A first
// CORDIC chain computes roll, yaw and the length sqrt(r21^2+r22^2), a
// gain multiply follows in two steps, and a second chain computes pitch.
// The whole pipeline advances together and holds when a result is stalled
// at the output register.
module rotation_matrix_to_euler import rme_pkg::*; #(
   parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [THR_WIDTH-1:0]          csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [FIELD_WIDTH-1:0] req_r00,
   input  logic signed [FIELD_WIDTH-1:0] req_r01,
   input  logic signed [FIELD_WIDTH-1:0] req_r02,
   input  logic signed [FIELD_WIDTH-1:0] req_r10,
   input  logic signed [FIELD_WIDTH-1:0] req_r11,
   input  logic signed [FIELD_WIDTH-1:0] req_r12,
   input  logic signed [FIELD_WIDTH-1:0] req_r20,
   input  logic signed [FIELD_WIDTH-1:0] req_r21,
   input  logic signed [FIELD_WIDTH-1:0] req_r22,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [FIELD_WIDTH-1:0] rsp_roll,
   output logic signed [FIELD_WIDTH-1:0] rsp_pitch,
   output logic [FIELD_WIDTH-1:0]        rsp_yaw,
   output logic                          rsp_singular
);

   localparam int SHIFT = 44 - DATA_WIDTH;
   localparam int TAGB  = 3;

   logic [THR_WIDTH-1:0] thr_ff;
   logic                 adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   function automatic vec_type sx(input logic [FIELD_WIDTH-1:0] v);
      logic [31:0] w;
      vec_type t;
      w = 32'(v);
      t = vec_type'(signed'(w[DATA_WIDTH-1:0]));
      return t <<< SHIFT;
   endfunction

   vec_type a00, a01, a02, a10, a11, a12, a20, a21, a22, thr_v;
   logic neg_s, pos_s;
   vec_type yx, yy;
   cordic_type c_in [3];
   logic z_in [3];

   always_comb begin
      a00 = sx(req_r00); a01 = sx(req_r01); a02 = sx(req_r02);
      a10 = sx(req_r10); a11 = sx(req_r11); a12 = sx(req_r12);
      a20 = sx(req_r20); a21 = sx(req_r21); a22 = sx(req_r22);
      thr_v = vec_type'(thr_ff) <<< SHIFT;
      neg_s = a20 <= -thr_v;
      pos_s = !neg_s && (a20 >= thr_v);
      if (neg_s) begin
         yx = a02 + a11; yy = a12 - a01;
      end else if (pos_s) begin
         yx = a02 - a11; yy = a12 + a01;
      end else begin
         yx = a00; yy = a10;
      end
      c_in[0] = cordic_pre(a22, a21);
      c_in[1] = cordic_pre(yx, yy);
      c_in[2] = cordic_pre(a22, a21);
      z_in[0] = (a22 == 0) && (a21 == 0);
      z_in[1] = (yx == 0) && (yy == 0);
      z_in[2] = z_in[0];
   end

   logic             v1;
   cordic_type       o1 [3];
   logic             oz1 [3];
   logic [TAGB-1:0]  t1;

   rme_chain #(.STAGES(CORDIC_STAGES), .TAG_BITS(TAGB)) u_chain_a (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(req_valid && req_ready), .in_lane(c_in), .in_zero(z_in),
      .in_tag({neg_s, pos_s, 1'b0}),
      .out_valid(v1), .out_lane(o1), .out_zero(oz1), .out_tag(t1)
   );

   // Gain removal in two registered steps.
   logic                   m_vld_ff, g_vld_ff;
   logic [VEC_WIDTH-16:0]  mhi_ff;
   logic [14:0]            mlo_ff;
   logic [VEC_WIDTH+15:0]  phi_ff;
   logic [45:0]            plo_ff;
   phase_type              roll_ff [2], yaw_ff [2];
   logic                   rz_ff [2], yz_ff [2];
   logic [TAGB-1:0]        mt_ff [2];
   vec_type                r20_ff [2];
   vec_type                r20_d [CORDIC_STAGES+1];
   vec_type                mag;

   // r20 travels with the item through the first chain.
   assign r20_d[0] = a20;
   for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_r20
      always_ff @(posedge clock) begin
         if (adv) r20_d[s+1] <= r20_d[s];
      end
   end

   assign mag = oz1[2] ? '0 : o1[2].x;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         m_vld_ff <= v1;
         g_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mhi_ff    <= mag[VEC_WIDTH-1:15];
         mlo_ff    <= mag[14:0];
         roll_ff[0] <= o1[0].z; rz_ff[0] <= oz1[0];
         yaw_ff[0]  <= o1[1].z; yz_ff[0] <= oz1[1];
         mt_ff[0]   <= t1;
         r20_ff[0]  <= r20_d[CORDIC_STAGES];
         phi_ff <= (VEC_WIDTH+16)'(mhi_ff) * (VEC_WIDTH+16)'(INV_GAIN_Q30);
         plo_ff <= 46'(mlo_ff) * 46'(INV_GAIN_Q30);
         roll_ff[1] <= roll_ff[0]; rz_ff[1] <= rz_ff[0];
         yaw_ff[1]  <= yaw_ff[0];  yz_ff[1] <= yz_ff[0];
         mt_ff[1]   <= mt_ff[0];
         r20_ff[1]  <= r20_ff[0];
      end
   end

   logic [VEC_WIDTH+15:0] lsum;
   vec_type len, py;
   cordic_type p_in [3];
   logic pz_in [3];

   always_comb begin
      lsum = phi_ff + (VEC_WIDTH+16)'(plo_ff >> 15);
      len  = vec_type'(lsum >> 15);
      py   = -r20_ff[1];
      p_in[0] = cordic_pre(len, py);
      p_in[1] = '0;
      p_in[2] = '0;
      pz_in[0] = (len == 0) && (py == 0);
      pz_in[1] = 1'b1;
      pz_in[2] = 1'b1;
   end

   logic            v2;
   cordic_type      o2 [3];
   logic            oz2 [3];
   logic [TAGB-1:0] t2;
   phase_type       rd_ff [CORDIC_STAGES], yd_ff [CORDIC_STAGES];

   rme_chain #(.STAGES(CORDIC_STAGES), .TAG_BITS(TAGB)) u_chain_b (
      .clock(clock), .reset(reset), .enable(adv),
      .in_valid(g_vld_ff), .in_lane(p_in), .in_zero(pz_in),
      .in_tag(mt_ff[1]),
      .out_valid(v2), .out_lane(o2), .out_zero(oz2), .out_tag(t2)
   );

   // Roll and yaw phases wait beside the pitch chain.
   localparam int NS = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   for (genvar s = 0; s < NS; s++) begin : g_dly
      always_ff @(posedge clock) begin
         if (adv) begin
            if (s == 0) begin
               rd_ff[0] <= rz_ff[1] || mt_ff[1][2] || mt_ff[1][1] ? '0 : roll_ff[1];
               yd_ff[0] <= (yz_ff[1] ? '0 : yaw_ff[1]) + (mt_ff[1][1] ? HALF_TURN : '0);
            end else begin
               rd_ff[s] <= rd_ff[(s == 0) ? 0 : s-1];
               yd_ff[s] <= yd_ff[(s == 0) ? 0 : s-1];
            end
         end
      end
   end

   function automatic logic [FIELD_WIDTH-1:0] to_ang(input phase_type p);
      logic [PH_WIDTH:0] r;
      logic [FIELD_WIDTH-1:0] o;
      if (ANGLE_WIDTH >= 32) begin
         o = FIELD_WIDTH'(p);
      end else begin
         r = {1'b0, p} + ((PH_WIDTH+1)'(1) << (31 - ANGLE_WIDTH));
         o = FIELD_WIDTH'(r >> (32 - ANGLE_WIDTH));
         if (ANGLE_WIDTH < FIELD_WIDTH) o = o & FIELD_WIDTH'((1 << ANGLE_WIDTH) - 1);
      end
      return o;
   endfunction

   phase_type pp;
   always_comb begin
      pp = oz2[0] ? '0 : o2[0].z;
      if (!pp[31] && pp > QUARTER_TURN) pp = QUARTER_TURN;
      if (pp[31] && pp < NEG_QUARTER) pp = NEG_QUARTER;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (adv) begin
         rsp_valid <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_roll     <= to_ang(rd_ff[NS-1]);
         rsp_pitch    <= to_ang(pp);
         rsp_yaw      <= to_ang(yd_ff[NS-1]);
         rsp_singular <= t2[2] || t2[1];
      end
   end

endmodule

>>> dv/rotation_matrix_to_euler_tb.sv
// ----------------------------------------------------------------------------
// Testbench for rotation matrix to ZYX Euler conversion
// Drives directed matrices and random bursts, checks roll, pitch, yaw and the
// singular flag against a bit-exact CORDIC predictor, and sweeps the
// gimbal-lock threshold through several settings.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_tb;
   import rme_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic [15:0]        yaw;
      logic               singular;
   } euler_type;

   typedef logic signed [15:0] entry_type;

   class euler_scoreboard;
      euler_type pending[$];
      logic [14:0] threshold;
      int errors;

      function new();
         threshold = THR_RESET;
         errors = 0;
      endfunction

      function logic [31:0] atan_step(input int i);
         logic [31:0] tab[32];
         tab = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                 32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                 32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
         return tab[i];
      endfunction

      function logic [31:0] phase_of(input longint x0, input longint y0,
                                     output longint mag);
         longint x, y, dx, dy;
         logic [31:0] z;
         x = x0;
         y = y0;
         z = 0;
         mag = 0;
         if (x == 0 && y == 0) return 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
         end
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
               x += dx;
               y -= dy;
               z += atan_step(i);
            end else begin
               x -= dx;
               y += dy;
               z -= atan_step(i);
            end
         end
         mag = x;
         return z;
      endfunction

      function logic [15:0] round_angle(input logic [31:0] ph);
         logic [32:0] s;
         s = {1'b0, ph} + 33'h8000;
         return s[31:16];
      endfunction

      function void note_request(input entry_type m[9]);
         longint r[9];
         longint mag, len, dummy, sp, thr;
         logic [31:0] roll_ph, pitch_ph, yaw_ph;
         euler_type e;
         for (int i = 0; i < 9; i++) r[i] = m[i];
         thr = threshold;
         roll_ph = phase_of(r[8] <<< 28, r[7] <<< 28, mag);
         len = ((mag >>> 15) * 64'sd652032874
                + (((mag & 64'h7FFF) * 64'sd652032874) >>> 15)) >>> 15;
         pitch_ph = phase_of(len, (-r[6]) <<< 28, dummy);
         sp = pitch_ph[31] ? longint'(pitch_ph) - 64'sh1_0000_0000 : longint'(pitch_ph);
         if (sp > 64'sh4000_0000) sp = 64'sh4000_0000;
         if (sp < -64'sh4000_0000) sp = -64'sh4000_0000;
         pitch_ph = sp[31:0];
         if (r[6] <= -thr) begin
            e.singular = 1;
            roll_ph = 0;
            yaw_ph = phase_of((r[2] + r[4]) <<< 28, (r[5] - r[1]) <<< 28, dummy);
         end else if (r[6] >= thr) begin
            e.singular = 1;
            roll_ph = 0;
            yaw_ph = 32'h8000_0000
                     + phase_of((r[2] - r[4]) <<< 28, (r[5] + r[1]) <<< 28, dummy);
         end else begin
            e.singular = 0;
            yaw_ph = phase_of(r[0] <<< 28, r[3] <<< 28, dummy);
         end
         e.roll = round_angle(roll_ph);
         e.pitch = round_angle(pitch_ph);
         e.yaw = round_angle(yaw_ph);
         pending.push_back(e);
      endfunction

      function void check_result(input euler_type a);
         euler_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d sing=%0b",
                     $time, a.roll, a.pitch, a.yaw, a.singular);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.roll !== e.roll) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, a.roll);
            errors++;
         end
         if (a.pitch !== e.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, a.pitch);
            errors++;
         end
         if (a.yaw !== e.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, a.yaw);
            errors++;
         end
         if (a.singular !== e.singular) begin
            $display("%0t: singular expected %0b actual %0b", $time, e.singular,
                     a.singular);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [14:0] csr_data = '0;
   logic req_valid = 0;
   logic req_ready;
   entry_type req_r00 = 0, req_r01 = 0, req_r02 = 0, req_r10 = 0, req_r11 = 0;
   entry_type req_r12 = 0, req_r20 = 0, req_r21 = 0, req_r22 = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [15:0] rsp_roll, rsp_pitch;
   logic [15:0] rsp_yaw;
   logic rsp_singular;

   euler_scoreboard board = new();
   int stall_mode = 0;
   bit hold_off = 0;

   rotation_matrix_to_euler uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_r00(req_r00), .req_r01(req_r01), .req_r02(req_r02),
      .req_r10(req_r10), .req_r11(req_r11), .req_r12(req_r12),
      .req_r20(req_r20), .req_r21(req_r21), .req_r22(req_r22),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll(rsp_roll), .rsp_pitch(rsp_pitch), .rsp_yaw(rsp_yaw),
      .rsp_singular(rsp_singular)
   );

   always #6 clock = ~clock;

   initial begin
      #50ms;
      $display("rotation_matrix_to_euler test failed");
      $finish;
   end

   always @(posedge clock) begin
      euler_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         a.roll = rsp_roll;
         a.pitch = rsp_pitch;
         a.yaw = rsp_yaw;
         a.singular = rsp_singular;
         board.check_result(a);
      end
      if (!reset && req_valid && req_ready)
         board.note_request('{req_r00, req_r01, req_r02, req_r10, req_r11,
                              req_r12, req_r20, req_r21, req_r22});
   end

   // The receiver stalls on a pattern chosen by stall_mode, and always while hold_off is set.
   always @(posedge clock) begin
      if (hold_off)
         rsp_ready <= 0;
      else case (stall_mode)
         0: rsp_ready <= 1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 1) == 0);
      endcase
   end

   initial begin
      wait (!reset);
      repeat (100) @(posedge clock);
      hold_off = 1;
      repeat (150) @(posedge clock);
      hold_off = 0;
   end

   task automatic send_request(input entry_type m[9]);
      req_r00 <= m[0]; req_r01 <= m[1]; req_r02 <= m[2];
      req_r10 <= m[3]; req_r11 <= m[4]; req_r12 <= m[5];
      req_r20 <= m[6]; req_r21 <= m[7]; req_r22 <= m[8];
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic entry_type any_entry();
      case ($urandom_range(0, 5))
         0: return entry_type'(16384);
         1: return entry_type'(-16384);
         2: return entry_type'($urandom());
         3: return entry_type'($urandom_range(0, 32)) - 16;
         default: return entry_type'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   function automatic entry_type near_edge(input logic [14:0] thr);
      int v;
      v = int'(thr) + int'($urandom_range(0, 6)) - 3;
      if ($urandom_range(0, 1)) v = -v;
      return entry_type'(v);
   endfunction

   task automatic send_random(input int count);
      entry_type m[9];
      int burst;
      while (count > 0) begin
         burst = $urandom_range(1, 30);
         while (burst > 0 && count > 0) begin
            foreach (m[i]) m[i] = any_entry();
            if ($urandom_range(0, 3) == 0) m[6] = near_edge(board.threshold);
            send_request(m);
            burst--;
            count--;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [14:0] value);
      csr_data <= value;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      board.threshold = value;
      @(posedge clock);
   endtask

   initial begin
      logic [14:0] settings[5];
      entry_type d[9];
      settings = '{15'd0, 15'd16384, 15'd32767, 15'd8000, THR_RESET};
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int k = 0; k < 20; k++) begin
         foreach (d[i]) d[i] = 0;
         case (k)
            0: ;
            1: foreach (d[i]) d[i] = 16384;
            2: foreach (d[i]) d[i] = -16384;
            3: begin d[0] = 16384; d[4] = 16384; d[8] = 16384; end
            4: begin d[0] = -16384; d[8] = -16384; end
            5: begin d[6] = -16384; d[2] = 5000; d[4] = -3000; d[5] = 700; end
            6: begin d[6] = 16384; d[1] = 900; d[2] = -800; d[4] = 2000; end
            7: d[6] = 16368;
            8: d[6] = -16368;
            9: d[6] = 16367;
            10: d[6] = -16367;
            11: begin d[8] = -9000; d[7] = 0; end
            12: begin d[0] = -16384; d[3] = 0; end
            13: begin d[6] = 1; d[7] = 16384; d[8] = 16384; end
            14: begin d[6] = -16384; d[2] = 16384; d[4] = -16384; end
            15: begin d[6] = 16384; d[2] = 16384; d[4] = 16384; end
            default: foreach (d[i]) d[i] = any_entry();
         endcase
         send_request(d);
      end
      req_valid <= 0;
      @(posedge clock);
      send_random(200);
      drain();

      foreach (settings[s]) begin
         write_threshold(settings[s]);
         stall_mode = s % 3;
         if (settings[s] == 0) begin
            foreach (d[i]) d[i] = 0;
            send_request(d);
            req_valid <= 0;
            @(posedge clock);
         end
         send_random(150);
         drain();
      end

      if (board.pending.size() == 0 && board.errors == 0)
         $display("rotation_matrix_to_euler test passed");
      else
         $display("rotation_matrix_to_euler test failed");
      $finish;
   end
endmodule
